### hdl/ethl4_pkg.sv
package ethl4_pkg;

    // header layout, byte offsets counted from the destination MAC
    localparam logic [5:0] EthIpLen  = 6'd34;
    localparam logic [5:0] UdpEnd    = 6'd42;
    localparam logic [5:0] TcpEnd    = 6'd54;
    localparam logic [5:0] ProtoPos  = 6'd23;
    localparam logic [3:0] NibbleMask = 4'h0F;

    // result queue depth
    localparam int QDepth = 3;

    // configuration register indexes (paddr[2])
    localparam logic CFG_TCP_PROTO = 1'b0;
    localparam logic CFG_UDP_PROTO = 1'b1;

    // field identifiers
    localparam logic [4:0] FID_DST_MAC     = 5'd0;
    localparam logic [4:0] FID_SRC_MAC     = 5'd1;
    localparam logic [4:0] FID_ETHERTYPE   = 5'd2;
    localparam logic [4:0] FID_VERSION     = 5'd3;
    localparam logic [4:0] FID_IHL         = 5'd4;
    localparam logic [4:0] FID_TOS         = 5'd5;
    localparam logic [4:0] FID_TOTAL_LEN   = 5'd6;
    localparam logic [4:0] FID_IDENT       = 5'd7;
    localparam logic [4:0] FID_FRAGMENT    = 5'd8;
    localparam logic [4:0] FID_TTL         = 5'd9;
    localparam logic [4:0] FID_PROTOCOL    = 5'd10;
    localparam logic [4:0] FID_IP_CSUM     = 5'd11;
    localparam logic [4:0] FID_SRC_ADDR    = 5'd12;
    localparam logic [4:0] FID_DST_ADDR    = 5'd13;
    localparam logic [4:0] FID_TCP_SPORT   = 5'd14;
    localparam logic [4:0] FID_TCP_DPORT   = 5'd15;
    localparam logic [4:0] FID_TCP_SEQ     = 5'd16;
    localparam logic [4:0] FID_TCP_ACK     = 5'd17;
    localparam logic [4:0] FID_DATA_OFFSET = 5'd18;
    localparam logic [4:0] FID_RESERVED    = 5'd19;
    localparam logic [4:0] FID_TCP_FLAGS   = 5'd20;
    localparam logic [4:0] FID_TCP_WINDOW  = 5'd21;
    localparam logic [4:0] FID_TCP_CSUM    = 5'd22;
    localparam logic [4:0] FID_TCP_URGENT  = 5'd23;
    localparam logic [4:0] FID_UDP_SPORT   = 5'd24;
    localparam logic [4:0] FID_UDP_DPORT   = 5'd25;
    localparam logic [4:0] FID_UDP_LEN     = 5'd26;
    localparam logic [4:0] FID_UDP_CSUM    = 5'd27;
    localparam logic [4:0] FID_PAYLOAD     = 5'd28;
    localparam logic [4:0] FID_UNKNOWN     = 5'd29;
    localparam logic [4:0] FID_TRUNCATED   = 5'd30;

    // transport state, one-hot
    typedef enum logic [2:0] {
        KIND_NONE = 3'b001,
        KIND_TCP  = 3'b010,
        KIND_UDP  = 3'b100
    } kind_t;

    // what a byte position does
    typedef enum logic [1:0] {
        DEC_NONE    = 2'd0,
        DEC_FIELD   = 2'd1,
        DEC_SPLIT   = 2'd2,
        DEC_PAYLOAD = 2'd3
    } dec_kind_t;

    typedef struct packed {
        dec_kind_t  kind;
        logic [4:0] id;
    } dec_t;

    // one result transaction
    typedef struct packed {
        logic [4:0]  id;
        logic [47:0] value;
        logic        frame_end;
    } res_t;

    // position decode: which field (if any) closes at this byte
    function automatic dec_t decode_pos(input logic [5:0] pos, input kind_t kind);
        dec_t       d;
        logic [5:0] off;
        d   = '{kind: DEC_NONE, id: FID_DST_MAC};
        off = pos - EthIpLen;
        if (pos < EthIpLen)
        begin
            case (pos)
                6'd5:    d = '{kind: DEC_FIELD, id: FID_DST_MAC};
                6'd11:   d = '{kind: DEC_FIELD, id: FID_SRC_MAC};
                6'd13:   d = '{kind: DEC_FIELD, id: FID_ETHERTYPE};
                6'd14:   d = '{kind: DEC_SPLIT, id: FID_VERSION};
                6'd15:   d = '{kind: DEC_FIELD, id: FID_TOS};
                6'd17:   d = '{kind: DEC_FIELD, id: FID_TOTAL_LEN};
                6'd19:   d = '{kind: DEC_FIELD, id: FID_IDENT};
                6'd21:   d = '{kind: DEC_FIELD, id: FID_FRAGMENT};
                6'd22:   d = '{kind: DEC_FIELD, id: FID_TTL};
                6'd23:   d = '{kind: DEC_FIELD, id: FID_PROTOCOL};
                6'd25:   d = '{kind: DEC_FIELD, id: FID_IP_CSUM};
                6'd29:   d = '{kind: DEC_FIELD, id: FID_SRC_ADDR};
                6'd33:   d = '{kind: DEC_FIELD, id: FID_DST_ADDR};
                default: d = '{kind: DEC_NONE,  id: FID_DST_MAC};
            endcase
        end
        else if (kind == KIND_TCP && pos < TcpEnd)
        begin
            case (off)
                6'd1:    d = '{kind: DEC_FIELD, id: FID_TCP_SPORT};
                6'd3:    d = '{kind: DEC_FIELD, id: FID_TCP_DPORT};
                6'd7:    d = '{kind: DEC_FIELD, id: FID_TCP_SEQ};
                6'd11:   d = '{kind: DEC_FIELD, id: FID_TCP_ACK};
                6'd12:   d = '{kind: DEC_SPLIT, id: FID_DATA_OFFSET};
                6'd13:   d = '{kind: DEC_FIELD, id: FID_TCP_FLAGS};
                6'd15:   d = '{kind: DEC_FIELD, id: FID_TCP_WINDOW};
                6'd17:   d = '{kind: DEC_FIELD, id: FID_TCP_CSUM};
                6'd19:   d = '{kind: DEC_FIELD, id: FID_TCP_URGENT};
                default: d = '{kind: DEC_NONE,  id: FID_DST_MAC};
            endcase
        end
        else if (kind == KIND_UDP && pos < UdpEnd)
        begin
            case (off)
                6'd1:    d = '{kind: DEC_FIELD, id: FID_UDP_SPORT};
                6'd3:    d = '{kind: DEC_FIELD, id: FID_UDP_DPORT};
                6'd5:    d = '{kind: DEC_FIELD, id: FID_UDP_LEN};
                6'd7:    d = '{kind: DEC_FIELD, id: FID_UDP_CSUM};
                default: d = '{kind: DEC_NONE,  id: FID_DST_MAC};
            endcase
        end
        else
        begin
            d = '{kind: DEC_PAYLOAD, id: FID_PAYLOAD};
        end
        return d;
    endfunction

endpackage

### hdl/eth_ipv4_l4_header_parser_unit.sv
// channel     | signals                            | payload
// ------------+------------------------------------+---------------------------------------
// byte in     | s_axis_tvalid/tready/tdata/tlast   | tdata[7:0] data_byte, tlast last_byte
// field out   | m_axis_tvalid/tready/tdata/tuser/  | tdata[47:0] field_value,
//             | tlast                              | tuser[4:0] field_id, tlast frame_end
// config      | psel/penable/pwrite/paddr/pwdata/  | 0x0 tcp_protocol_number,
//             | prdata/pready                      | 0x4 udp_protocol_number
//
// one byte is accepted per cycle while s_axis_tready is high; its results are written into a three-entry
// result queue at the accepting edge, and the registered head of that queue drives the output.
// the first IPv4 byte, the TCP offset byte and an unknown protocol byte give two
// results, so with the output always ready the input stalls after them.
// s_axis_tready depends only on the queue fill, never on m_axis_tready.
// rst_n clears the frame state, the queue fill and restores both protocol registers.
module eth_ipv4_l4_header_parser_unit
    import ethl4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [47:0] field_value
    output logic [4:0]  m_axis_tuser,   // [4:0] field_id
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  tcp_proto_reg;
    logic [7:0]  udp_proto_reg;
    logic [5:0]  pos_reg,  pos_next;
    logic [47:0] acc_reg,  acc_next;
    kind_t       kind_reg, kind_next;
    logic        drop_reg, drop_next;

    res_t        q_reg  [QDepth];
    res_t        q_next [QDepth];
    logic [1:0]  count_reg, count_next;

    logic        s_accept;
    logic        m_accept;
    logic        cfg_write;
    res_t        r0, r1;
    logic [1:0]  npush;
    dec_t        dec;
    logic [47:0] acc_shift;
    logic [4:0]  split_id;
    logic [1:0]  base;

    assign s_accept  = s_axis_tvalid & s_axis_tready;
    assign m_accept  = m_axis_tvalid & m_axis_tready;
    assign cfg_write = psel & penable & pwrite & pready;

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            CFG_TCP_PROTO: prdata = {24'd0, tcp_proto_reg};
            CFG_UDP_PROTO: prdata = {24'd0, udp_proto_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcp_proto_reg <= 8'd6;
            udp_proto_reg <= 8'd17;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                CFG_TCP_PROTO: tcp_proto_reg <= pwdata[7:0];
                CFG_UDP_PROTO: udp_proto_reg <= pwdata[7:0];
                default:       tcp_proto_reg <= tcp_proto_reg;
            endcase
        end
    end

    // per-byte decode and frame state update
    always_comb
    begin
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        kind_next = kind_reg;
        drop_next = drop_reg;
        r0        = '{id: FID_TRUNCATED, value: 48'd0, frame_end: 1'b0};
        r1        = '{id: FID_TRUNCATED, value: 48'd0, frame_end: 1'b0};
        npush     = 2'd0;
        dec       = decode_pos(pos_reg, kind_reg);
        acc_shift = {acc_reg[39:0], s_axis_tdata};
        split_id  = (pos_reg < EthIpLen) ? FID_VERSION : FID_DATA_OFFSET;

        if (!drop_reg)
        begin
            if (dec.kind == DEC_PAYLOAD)
            begin
                r0    = '{id: FID_PAYLOAD, value: {40'd0, s_axis_tdata}, frame_end: 1'b0};
                npush = 2'd1;
            end
            else
            begin
                acc_next = acc_shift;
                if (dec.kind == DEC_SPLIT)
                begin
                    r0 = '{id: split_id, value: {44'd0, s_axis_tdata[7:4]}, frame_end: 1'b0};
                    r1 = '{id: split_id + 5'd1,
                           value: {44'd0, s_axis_tdata[3:0] & NibbleMask},
                           frame_end: 1'b0};
                    npush    = 2'd2;
                    acc_next = 48'd0;
                end
                else if (dec.kind == DEC_FIELD)
                begin
                    r0       = '{id: dec.id, value: acc_shift, frame_end: 1'b0};
                    npush    = 2'd1;
                    acc_next = 48'd0;
                end

                // protocol byte picks the transport header
                if (pos_reg == ProtoPos)
                begin
                    if (s_axis_tdata == tcp_proto_reg)
                    begin
                        kind_next = KIND_TCP;
                    end
                    else if (s_axis_tdata == udp_proto_reg)
                    begin
                        kind_next = KIND_UDP;
                    end
                    else
                    begin
                        r1 = '{id: FID_UNKNOWN, value: {40'd0, s_axis_tdata},
                               frame_end: 1'b0};
                        npush     = 2'd2;
                        drop_next = 1'b1;
                    end
                end
                pos_next = pos_reg + 6'd1;
            end

            // end of frame marks the final result, or pushes a truncation marker when the byte gave none
            if (s_axis_tlast)
            begin
                if (npush == 2'd0)
                begin
                    npush = 2'd1;
                end
                if (npush == 2'd2)
                begin
                    r1.frame_end = 1'b1;
                end
                else
                begin
                    r0.frame_end = 1'b1;
                end
            end
        end

        if (s_axis_tlast)
        begin
            pos_next  = 6'd0;
            acc_next  = 48'd0;
            kind_next = KIND_NONE;
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 6'd0;
            acc_reg  <= 48'd0;
            kind_reg <= KIND_NONE;
            drop_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            kind_reg <= kind_next;
            drop_reg <= drop_next;
        end
    end

    // result queue, head at entry 0
    always_comb
    begin
        q_next = q_reg;
        base   = count_reg - {1'b0, m_accept};
        if (m_accept)
        begin
            for (int i = 0; i < QDepth - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        if (s_accept)
        begin
            for (int i = 0; i < QDepth; i++)
            begin
                if (npush != 2'd0 && 2'(i) == base)
                begin
                    q_next[i] = r0;
                end
                if (npush == 2'd2 && 2'(i) == base + 2'd1)
                begin
                    q_next[i] = r1;
                end
            end
            count_next = base + npush;
        end
        else
        begin
            count_next = base;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign s_axis_tready = (count_reg <= 2'(QDepth - 2));
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = q_reg[0].value;
    assign m_axis_tuser  = q_reg[0].id;
    assign m_axis_tlast  = q_reg[0].frame_end;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDepth))
        else $error("result queue overfilled");

    // last byte returns the frame state to its start
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tlast |=>
            pos_reg == 6'd0 && kind_reg == KIND_NONE && !drop_reg)
        else $error("frame state not cleared after last byte");

    // dropping only happens before a transport is chosen
    assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> kind_reg == KIND_NONE)
        else $error("dropping with a known transport");

    // position stops at the end of the longest header
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= TcpEnd)
        else $error("byte position past header end");

    // a byte that is not dropped always yields a result at frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tlast && !drop_reg |=> m_axis_tvalid)
        else $error("frame end produced no result");

endmodule

### verif/tb_top.sv
module tb_top
    import ethl4_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit   = 200000;
    localparam int PhaseBytes   = 195;
    localparam int DrainCycles  = 4;
    localparam int IdlePercent  = 14;
    localparam int PrintLimit   = 40;

    // expected field transactions, worked out from each accepted frame byte
    class header_field_scoreboard;
        res_t       pending_fields[$];
        int         mismatches;
        logic [7:0] tcp_proto;
        logic [7:0] udp_proto;
        logic [5:0] byte_pos;
        logic [47:0] field_acc;
        kind_t      transport;
        bit         dropping;

        function new();
            mismatches = 0;
            tcp_proto  = 8'd6;
            udp_proto  = 8'd17;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            field_acc = '0;
            transport = KIND_NONE;
            dropping  = 1'b0;
        endfunction

        function void set_register(input logic idx, input logic [7:0] value);
            if (idx == CFG_TCP_PROTO)
                tcp_proto = value;
            else
                udp_proto = value;
        endfunction

        function int pending();
            return pending_fields.size();
        endfunction

        task report(input string msg);
            if (mismatches < PrintLimit)
                $display("tb_top: mismatch: %s", msg);
            mismatches++;
        endtask

        function void push_field(input logic [4:0] id, input logic [47:0] value);
            res_t r;
            r.id        = id;
            r.value     = value;
            r.frame_end = 1'b0;
            pending_fields.push_back(r);
        endfunction

        // fields that close at the current byte, then frame-level effects
        function void note_byte(input logic [7:0] b, input logic last);
            logic [4:0] fid;
            logic [4:0] fid_low;
            logic [5:0] rel;
            bit         closes;
            bit         splits;
            bit         payload;
            int         before_cnt;
            res_t       tail;

            if (dropping)
            begin
                if (last)
                    clear_frame();
                return;
            end
            before_cnt = pending_fields.size();
            closes  = 1'b1;
            splits  = 1'b0;
            payload = 1'b0;
            fid     = FID_PAYLOAD;
            fid_low = FID_PAYLOAD;
            rel     = byte_pos - EthIpLen;

            if (byte_pos < EthIpLen)
            begin
                case (byte_pos)
                    6'd5:  fid = FID_DST_MAC;
                    6'd11: fid = FID_SRC_MAC;
                    6'd13: fid = FID_ETHERTYPE;
                    6'd14:
                    begin
                        splits  = 1'b1;
                        fid     = FID_VERSION;
                        fid_low = FID_IHL;
                    end
                    6'd15: fid = FID_TOS;
                    6'd17: fid = FID_TOTAL_LEN;
                    6'd19: fid = FID_IDENT;
                    6'd21: fid = FID_FRAGMENT;
                    6'd22: fid = FID_TTL;
                    6'd23: fid = FID_PROTOCOL;
                    6'd25: fid = FID_IP_CSUM;
                    6'd29: fid = FID_SRC_ADDR;
                    6'd33: fid = FID_DST_ADDR;
                    default: closes = 1'b0;
                endcase
            end
            else if (transport == KIND_TCP && byte_pos < TcpEnd)
            begin
                case (rel)
                    6'd1:  fid = FID_TCP_SPORT;
                    6'd3:  fid = FID_TCP_DPORT;
                    6'd7:  fid = FID_TCP_SEQ;
                    6'd11: fid = FID_TCP_ACK;
                    6'd12:
                    begin
                        splits  = 1'b1;
                        fid     = FID_DATA_OFFSET;
                        fid_low = FID_RESERVED;
                    end
                    6'd13: fid = FID_TCP_FLAGS;
                    6'd15: fid = FID_TCP_WINDOW;
                    6'd17: fid = FID_TCP_CSUM;
                    6'd19: fid = FID_TCP_URGENT;
                    default: closes = 1'b0;
                endcase
            end
            else if (transport == KIND_UDP && byte_pos < UdpEnd)
            begin
                case (rel)
                    6'd1: fid = FID_UDP_SPORT;
                    6'd3: fid = FID_UDP_DPORT;
                    6'd5: fid = FID_UDP_LEN;
                    6'd7: fid = FID_UDP_CSUM;
                    default: closes = 1'b0;
                endcase
            end
            else
            begin
                payload = 1'b1;
            end

            if (payload)
            begin
                push_field(FID_PAYLOAD, {40'd0, b});
            end
            else
            begin
                field_acc = {field_acc[39:0], b};
                if (splits)
                begin
                    push_field(fid, {44'd0, b[7:4]});
                    push_field(fid_low, {44'd0, b[3:0] & NibbleMask});
                    field_acc = '0;
                end
                else if (closes)
                begin
                    push_field(fid, field_acc);
                    field_acc = '0;
                end
                // protocol byte picks the transport header
                if (byte_pos == ProtoPos)
                begin
                    if (b == tcp_proto)
                        transport = KIND_TCP;
                    else if (b == udp_proto)
                        transport = KIND_UDP;
                    else
                    begin
                        push_field(FID_UNKNOWN, {40'd0, b});
                        dropping = 1'b1;
                    end
                end
                byte_pos = byte_pos + 6'd1;
            end

            // frame end: mark the last field, or a truncation marker
            if (last)
            begin
                if (pending_fields.size() == before_cnt)
                    push_field(FID_TRUNCATED, '0);
                tail = pending_fields[pending_fields.size() - 1];
                tail.frame_end = 1'b1;
                pending_fields[pending_fields.size() - 1] = tail;
                clear_frame();
            end
        endfunction

        task check_field(input logic [4:0] id, input logic [47:0] value, input logic fe);
            res_t want;
            if (pending_fields.size() == 0)
            begin
                report($sformatf("field %0d value %h with nothing expected", id, value));
                return;
            end
            want = pending_fields.pop_front();
            if (id !== want.id)
                report($sformatf("field_id got %0d want %0d", id, want.id));
            if (value !== want.value)
                report($sformatf("field %0d value got %h want %h", want.id, value, want.value));
            if (fe !== want.frame_end)
                report($sformatf("field %0d frame_end got %b want %b", want.id, fe,
                                 want.frame_end));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [47:0] field_value
    logic [4:0]  m_axis_tuser;          // [4:0] field_id
    logic        m_axis_tlast;          // frame_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    header_field_scoreboard sb = new();
    bit steady = 1'b0;
    int bytes_sent = 0;
    int cycles = 0;

    eth_ipv4_l4_header_parser_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // field side: check each transaction, stall at random unless steady is set
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_field(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IdlePercent);
    end

    // one byte transaction, with random gaps ahead of it unless steady is set
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(0, 99) < IdlePercent)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // stop sending and let every expected field come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom_range(0, 16777215)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(input logic idx, input logic [7:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {24'd0, want})
            sb.report($sformatf("register %0d read %h want %h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_protocols(input logic [7:0] tcp_val, input logic [7:0] udp_val);
        write_reg(CFG_TCP_PROTO, tcp_val);
        write_reg(CFG_UDP_PROTO, udp_val);
        read_reg(CFG_TCP_PROTO, tcp_val);
        read_reg(CFG_UDP_PROTO, udp_val);
    endtask

    task automatic send_frame(input int len, input logic [7:0] proto);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = (i == ProtoPos) ? proto : 8'($urandom());
            send_byte(b, i == len - 1);
        end
    endtask

    // mostly well-formed tcp/udp frames, some truncated, some unknown protocol
    task automatic random_frame();
        int         pick;
        int         hdr;
        int         len;
        logic [7:0] proto;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            proto = sb.tcp_proto;
        else if (pick < 75)
            proto = sb.udp_proto;
        else if (pick < 88)
        begin
            proto = 8'($urandom());
            while (proto == sb.tcp_proto || proto == sb.udp_proto)
                proto = 8'($urandom());
        end
        else
            proto = 8'($urandom());
        if (proto == sb.tcp_proto)
            hdr = TcpEnd;
        else if (proto == sb.udp_proto)
            hdr = UdpEnd;
        else
            hdr = ProtoPos + 1;
        if ($urandom_range(0, 99) < 15)
            len = $urandom_range(1, hdr);
        else if ($urandom_range(0, 99) < 5)
            len = hdr + $urandom_range(0, 40);
        else
            len = hdr + $urandom_range(0, 12);
        send_frame(len, proto);
    endtask

    task automatic random_phase();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < PhaseBytes)
            random_frame();
    endtask

    initial
    begin
        logic [7:0] both;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the protocol registers
        read_reg(CFG_TCP_PROTO, 8'd6);
        read_reg(CFG_UDP_PROTO, 8'd17);

        // one-byte frame: truncation marker
        send_byte(8'hFF, 1'b1);
        // frame ending inside the ethernet header
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        // all-ones dst mac, all-zero src mac, ending on the split ip byte
        for (int i = 0; i < 6; i++)
            send_byte(8'hFF, 1'b0);
        for (int i = 0; i < 6; i++)
            send_byte(8'h00, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hF0, 1'b1);

        random_phase();

        // sender holds off until the block has caught up
        drain();
        random_phase();
        drain();

        set_protocols(8'd0, 8'd255);
        steady = 1'b1;
        random_phase();
        drain();
        steady = 1'b0;

        set_protocols(8'd255, 8'd0);
        random_phase();
        drain();

        // same value in both registers: tcp wins
        both = 8'($urandom());
        set_protocols(both, both);
        random_phase();
        drain();

        set_protocols(8'($urandom()), 8'($urandom()));
        random_phase();
        drain();

        set_protocols(8'd6, 8'd17);
        random_phase();
        drain();

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/ethl4_pkg.sv
hdl/eth_ipv4_l4_header_parser_unit.sv
verif/tb_top.sv
